/* sv/depq_pkg.sv */
`default_nettype none

package depq_pkg;

    // Store geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KEY_W  = 31;
    localparam int PRIO_W = 32;

    // Request kinds
    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_POP_MAX = 2'd1;
    localparam logic [1:0] FUNC_POP_MIN = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // One stored entry
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [KEY_W-1:0]         key;
    } entry_t;

    // What every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_DOWN
    } cell_op_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t         op;
        entry_t           new_entry;
        logic [CNT_W-1:0] count;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/double_ended_priority_queue.sv */
`default_nettype none

// Double-ended priority queue built as a sorted chain of CAPACITY cells, lowest
// priority in cell 0. Each request word (insert, pop highest, pop lowest) is taken
// and gives exactly one result word, registered for the next cycle; a new request
// is accepted every cycle while the result register is free or being drained. An
// insert compares against all cells at once and the cells above the slot shift up
// one place; a pop-min shifts every cell down one place; a pop-max only lowers the
// fill count. Equal priorities keep arrival order: pop-max returns the newest and
// pop-min the oldest. A pop on an empty queue returns key 0 with status 1; an
// insert into a full queue is dropped with status 2; kind 3 only returns key 0, status 0.
module double_ended_priority_queue
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    func,
    input  wire logic [depq_pkg::KEY_W-1:0]    client_key,
    input  wire logic signed [depq_pkg::PRIO_W-1:0] prio,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [depq_pkg::KEY_W-1:0]         popped_key,
    output logic [1:0]                         status
);

    localparam int N = depq_pkg::CAPACITY;

    logic [depq_pkg::CNT_W-1:0] count_reg;
    logic [depq_pkg::CNT_W-1:0] count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [depq_pkg::KEY_W-1:0] key_reg;
    logic [depq_pkg::KEY_W-1:0] key_next;
    logic [1:0]                 status_reg;
    logic [1:0]                 status_next;

    depq_pkg::cell_ctrl_t       ctrl;
    depq_pkg::entry_t           cell_entry [N];
    logic                       cell_gt    [N];
    logic [depq_pkg::KEY_W-1:0] cell_top   [N];
    logic [depq_pkg::KEY_W-1:0] max_key;
    logic                       accept;
    logic                       is_empty;
    logic                       is_full;

    // Hold the request while the result register is full and stalled
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_empty = count_reg == '0;
    assign is_full  = count_reg == depq_pkg::CNT_W'(N);

    // Gather the key of the highest occupied cell
    always_comb
    begin
        max_key = '0;
        for (int i = 0; i < N; i++)
        begin
            max_key = max_key | cell_top[i];
        end
    end

    // Decode the request into a cell operation and a result word
    always_comb
    begin
        ctrl.op        = depq_pkg::CELL_HOLD;
        ctrl.new_entry = '{prio: prio, key: client_key};
        ctrl.count     = count_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
            key_next       = '0;
            status_next    = depq_pkg::STATUS_OK;
            case (func)
                depq_pkg::FUNC_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = depq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ctrl.op    = depq_pkg::CELL_INSERT;
                        count_next = count_reg + depq_pkg::CNT_W'(1);
                    end
                end
                depq_pkg::FUNC_POP_MAX:
                begin
                    if (is_empty)
                    begin
                        status_next = depq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        key_next   = max_key;
                        count_next = count_reg - depq_pkg::CNT_W'(1);
                    end
                end
                depq_pkg::FUNC_POP_MIN:
                begin
                    if (is_empty)
                    begin
                        status_next = depq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        ctrl.op    = depq_pkg::CELL_SHIFT_DOWN;
                        key_next   = cell_entry[0].key;
                        count_next = count_reg - depq_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    ctrl.op = depq_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    // Chain of cells, each linked to its two neighbours
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        depq_pkg::entry_t lower_entry;
        logic             lower_gt;
        depq_pkg::entry_t upper_entry;

        if (g == 0)
        begin : g_bottom
            assign lower_entry = ctrl.new_entry;
            assign lower_gt    = 1'b0;
        end
        else
        begin : g_lower
            assign lower_entry = cell_entry[g-1];
            assign lower_gt    = cell_gt[g-1];
        end

        if (g == N - 1)
        begin : g_top
            assign upper_entry = cell_entry[g];
        end
        else
        begin : g_upper
            assign upper_entry = cell_entry[g+1];
        end

        depq_cell u_cell
        (
            .clk         (clk),
            .cell_idx    (depq_pkg::IDX_W'(g)),
            .ctrl        (ctrl),
            .lower_entry (lower_entry),
            .lower_gt    (lower_gt),
            .upper_entry (upper_entry),
            .entry       (cell_entry[g]),
            .gt          (cell_gt[g]),
            .top_key     (cell_top[g])
        );
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        status_reg <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign popped_key = key_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

/* sv/depq_cell.sv */
`default_nettype none

module depq_cell
(
    input  wire logic                        clk,
    input  wire logic [depq_pkg::IDX_W-1:0]  cell_idx,
    input  wire depq_pkg::cell_ctrl_t        ctrl,
    input  wire depq_pkg::entry_t            lower_entry,
    input  wire logic                        lower_gt,
    input  wire depq_pkg::entry_t            upper_entry,
    output depq_pkg::entry_t                 entry,
    output logic                             gt,
    output logic [depq_pkg::KEY_W-1:0]       top_key
);

    depq_pkg::entry_t entry_reg;
    depq_pkg::entry_t entry_next;

    logic                         occupied;
    logic                         is_tail;
    logic [depq_pkg::CNT_W-1:0]   idx_ext;

    // Decode this cell's place relative to the fill level
    always_comb
    begin
        idx_ext  = depq_pkg::CNT_W'(cell_idx);
        occupied = idx_ext < ctrl.count;
        is_tail  = idx_ext == ctrl.count;
        gt       = occupied && (entry_reg.prio > ctrl.new_entry.prio);
        top_key  = ((idx_ext + depq_pkg::CNT_W'(1)) == ctrl.count) ?
                   entry_reg.key : '0;
    end

    // Move up on insert above the slot, take the new word at the slot, shift down on pop-min
    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            depq_pkg::CELL_INSERT:
            begin
                if (lower_gt)
                begin
                    entry_next = lower_entry;
                end
                else if (gt || is_tail)
                begin
                    entry_next = ctrl.new_entry;
                end
            end
            depq_pkg::CELL_SHIFT_DOWN:
            begin
                entry_next = upper_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
